>>> hw/rtl/ipv6ehw_pkg.sv
// Shared types, constants and helpers for the IPv6 extension header walker.
// No dependencies; used by ipv6ehw_core and the top level.
`default_nettype none

package ipv6ehw_pkg;

    // Packet positions at and beyond this offset are not walked
    localparam int unsigned MAX_PACKET_BYTES = 65536;
    localparam int unsigned POS_W            = $clog2(MAX_PACKET_BYTES + 1);
    localparam int unsigned HLEN_W           = 12;

    // Fixed layout of the IPv6 base header
    localparam logic [POS_W-1:0] BASE_LEN      = POS_W'(40);
    localparam logic [POS_W-1:0] TYPE_BYTE_POS = POS_W'(6);

    // Next-header codes with special meaning
    localparam logic [7:0] NH_HOP_BY_HOP = 8'd0;
    localparam logic [7:0] NH_ROUTING    = 8'd43;
    localparam logic [7:0] NH_FRAGMENT   = 8'd44;
    localparam logic [7:0] NH_AUTH       = 8'd51;
    localparam logic [7:0] NH_NONE       = 8'd59;
    localparam logic [7:0] NH_DEST_OPTS  = 8'd60;
    localparam logic [7:0] NH_MOBILITY   = 8'd135;
    localparam logic [7:0] NH_HIP        = 8'd139;
    localparam logic [7:0] NH_SHIM6      = 8'd140;
    localparam logic [7:0] PROTO_ERROR   = 8'd0;

    localparam logic [HLEN_W-1:0] FRAG_LEN = HLEN_W'(8);

    typedef struct packed {
        logic [POS_W-1:0] transport_offset;
        logic [7:0]       upper_protocol;
    } result_t;

    // Extension headers whose length comes from their second byte
    function automatic logic is_sized_ext(input logic [7:0] t);
        return (t == NH_HOP_BY_HOP) || (t == NH_ROUTING) || (t == NH_AUTH) ||
               (t == NH_DEST_OPTS) || (t == NH_MOBILITY) || (t == NH_HIP) ||
               (t == NH_SHIM6);
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ipv6ehw_core.sv
// Per-packet walk state: consumes one byte per step and flags the result.
// Depends on ipv6ehw_pkg.
`default_nettype none

module ipv6ehw_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic [7:0]            byte_value,
    input  wire logic                  last_byte,
    output logic                       res_valid,
    output ipv6ehw_pkg::result_t       res
);

    localparam logic [2:0] PH_BASE  = 3'd0;
    localparam logic [2:0] PH_FIRST = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_BODY  = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;

    localparam int unsigned PW = ipv6ehw_pkg::POS_W;
    localparam int unsigned LW = ipv6ehw_pkg::HLEN_W;

    logic [PW-1:0] pos_reg, pos_next;
    logic [7:0]    cur_type_reg, cur_type_next;
    logic [7:0]    pend_type_reg, pend_type_next;
    logic [PW-1:0] hdr_start_reg, hdr_start_next;
    logic [LW-1:0] hdr_len_reg, hdr_len_next;
    logic [2:0]    phase_reg, phase_next;
    logic          sent_reg, sent_next;

    logic [PW:0]   hdr_end;
    logic [PW:0]   pos_plus1;

    assign hdr_end   = {1'b0, hdr_start_reg} + {(PW + 1 - LW)'(0), hdr_len_reg};
    assign pos_plus1 = {1'b0, pos_reg} + (PW + 1)'(1);

    // Next-state and result logic for one byte
    always_comb
    begin
        pos_next       = pos_reg;
        cur_type_next  = cur_type_reg;
        pend_type_next = pend_type_reg;
        hdr_start_next = hdr_start_reg;
        hdr_len_next   = hdr_len_reg;
        phase_next     = phase_reg;
        sent_next      = sent_reg;
        res_valid      = 1'b0;
        res.upper_protocol   = ipv6ehw_pkg::PROTO_ERROR;
        res.transport_offset = hdr_start_reg;

        if (pos_reg < PW'(ipv6ehw_pkg::MAX_PACKET_BYTES))
        begin
            unique case (phase_reg)
                PH_BASE:
                begin
                    if (pos_reg == ipv6ehw_pkg::TYPE_BYTE_POS)
                        cur_type_next = byte_value;
                    if (pos_reg == ipv6ehw_pkg::BASE_LEN - PW'(1))
                    begin
                        hdr_start_next = ipv6ehw_pkg::BASE_LEN;
                        phase_next     = PH_FIRST;
                    end
                end
                PH_FIRST:
                begin
                    if (ipv6ehw_pkg::is_sized_ext(cur_type_reg))
                    begin
                        pend_type_next = byte_value;
                        phase_next     = PH_LEN;
                    end
                    else if (cur_type_reg == ipv6ehw_pkg::NH_FRAGMENT)
                    begin
                        pend_type_next = byte_value;
                        hdr_len_next   = ipv6ehw_pkg::FRAG_LEN;
                        phase_next     = PH_BODY;
                    end
                    else
                    begin
                        // no-next-header reports an error, anything else is found
                        res_valid = 1'b1;
                        if (cur_type_reg != ipv6ehw_pkg::NH_NONE)
                            res.upper_protocol = cur_type_reg;
                        sent_next  = 1'b1;
                        phase_next = PH_DONE;
                    end
                end
                PH_LEN:
                begin
                    // 8 + 8 * length byte
                    hdr_len_next = {1'b0, byte_value, 3'b000} + LW'(8);
                    phase_next   = PH_BODY;
                end
                PH_BODY:
                begin
                    if (pos_plus1 == hdr_end)
                    begin
                        hdr_start_next = hdr_end[PW-1:0];
                        cur_type_next  = pend_type_reg;
                        phase_next     = PH_FIRST;
                    end
                end
                default:
                begin
                end
            endcase
            pos_next = pos_plus1[PW-1:0];
        end

        // End of packet: report failure if nothing went out, then clear
        if (last_byte)
        begin
            if (!sent_next)
            begin
                res_valid            = 1'b1;
                res.upper_protocol   = ipv6ehw_pkg::PROTO_ERROR;
                res.transport_offset = (phase_next == PH_BASE) ? PW'(0) : hdr_start_next;
            end
            pos_next       = '0;
            cur_type_next  = '0;
            pend_type_next = '0;
            hdr_start_next = '0;
            hdr_len_next   = '0;
            phase_next     = PH_BASE;
            sent_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            cur_type_reg  <= '0;
            pend_type_reg <= '0;
            hdr_start_reg <= '0;
            hdr_len_reg   <= '0;
            phase_reg     <= PH_BASE;
            sent_reg      <= 1'b0;
        end
        else if (step)
        begin
            pos_reg       <= pos_next;
            cur_type_reg  <= cur_type_next;
            pend_type_reg <= pend_type_next;
            hdr_start_reg <= hdr_start_next;
            hdr_len_reg   <= hdr_len_next;
            phase_reg     <= phase_next;
            sent_reg      <= sent_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ipv6_extension_header_walker_top.sv
// Top level of the IPv6 extension header walker: stream ports, input and
// result registers. Depends on ipv6ehw_pkg and ipv6ehw_core.
`default_nettype none

// The walker takes one packet byte per beat on s_axis, tlast marking the
// packet's final byte, and gives exactly one result beat per packet on
// m_axis: the upper-layer protocol number (0 on error) and the byte offset
// where the walk stopped. It sustains one byte per clock while m_axis does not
// stall; the byte that causes a result beat passes the input register, then the
// result register, and the beat is held there while m_axis stalls.
// The result arrives at the first byte of the upper-layer header or of a
// no-next-header, or at the last byte when the packet is short or ends
// inside or right after a header.
module ipv6_extension_header_walker_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  wire logic        s_axis_tlast,   // last_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // [7:0] upper_protocol, [24:8] transport_offset
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 in_last_reg;
    logic                 out_valid_reg;
    ipv6ehw_pkg::result_t out_res_reg;

    logic                 step;
    logic                 res_valid;
    ipv6ehw_pkg::result_t res;

    // Advance the held byte when the result slot is free or draining
    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    ipv6ehw_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .byte_value (in_byte_reg),
        .last_byte  (in_last_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step && res_valid)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
            out_res_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_res_reg.transport_offset, out_res_reg.upper_protocol};

endmodule

`default_nettype wire
